### sv/idea_pkg.sv
// IDEA cipher shared package: block and subkey types, modular multiply
// helpers and key schedule word selection. No dependencies.
package idea_pkg;

   localparam int ROUNDS_DEF = 8;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_UPPER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOWER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = 2'd2;

   typedef struct packed {
      logic [15:0] x1;
      logic [15:0] x2;
      logic [15:0] x3;
      logic [15:0] x4;
   } blk_type;

   typedef logic [5:0][15:0] subkeys_type;

   // First half of a multiply mod 65537: raw product plus the zero-operand answer.
   typedef struct packed {
      logic [31:0] prod;
      logic [15:0] alt;
      logic        zero;
   } mul_part_type;

   function automatic mul_part_type mul_start(input logic [15:0] a, input logic [15:0] b);
      mul_part_type m;
      m.zero = (a == 16'd0) || (b == 16'd0);
      m.alt  = (a == 16'd0) ? 16'(16'd1 - b) : 16'(16'd1 - a);
      m.prod = 32'(a) * 32'(b);
      return m;
   endfunction

   // Second half: fold high word into low word mod 65537.
   function automatic logic [15:0] mul_finish(input mul_part_type m);
      logic [15:0] lo;
      logic [15:0] hi;
      lo = m.prod[15:0];
      hi = m.prod[31:16];
      if (m.zero) return m.alt;
      return 16'(lo - hi + ((lo < hi) ? 16'd1 : 16'd0));
   endfunction

   // Encryption subkey k: key rotated left by 25 bits per group of eight words.
   function automatic logic [15:0] ek_word(input logic [127:0] key, input int k);
      int          rot;
      int          w;
      logic [127:0] r;
      rot = (25 * (k / 8)) % 128;
      w   = k % 8;
      r   = (rot == 0) ? key : ((key << rot) | (key >> (128 - rot)));
      return r[127 - 16*w -: 16];
   endfunction

endpackage

### sv/idea_round_cell.sv
// One IDEA round as a four-stage pipeline cell.
// Depends on idea_pkg.
module idea_round_cell import idea_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  blk_type     in_blk,
   input  subkeys_type keys,
   output logic        out_valid,
   output blk_type     out_blk
);
   logic         va_ff, vb_ff, vc_ff, vd_ff;
   mul_part_type p1_ff, p4_ff, p3_ff, p5_ff;
   logic [15:0]  x2a_ff, x3a_ff;
   logic [15:0]  x1b_ff, x2b_ff, x3b_ff, x4b_ff;
   logic [15:0]  x1c_ff, x2c_ff, x3c_ff, x4c_ff, x3m_ff;
   blk_type      out_ff;

   logic [15:0]  x1r, x4r, x3m_in, x2m, x3n;
   blk_type      out_in;

   always_comb begin
      x1r    = mul_finish(p1_ff);
      x4r    = mul_finish(p4_ff);
      x3m_in = mul_finish(p3_ff);
      x2m    = mul_finish(p5_ff);
      x3n    = 16'(x3m_ff + x2m);
      out_in.x1 = x1c_ff ^ x2m;
      out_in.x4 = x4c_ff ^ x3n;
      out_in.x2 = x2m ^ x3c_ff;
      out_in.x3 = x3n ^ x2c_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
      p1_ff  <= mul_start(in_blk.x1, keys[0]);
      x2a_ff <= 16'(in_blk.x2 + keys[1]);
      x3a_ff <= 16'(in_blk.x3 + keys[2]);
      p4_ff  <= mul_start(in_blk.x4, keys[3]);
      x1b_ff <= x1r;
      x2b_ff <= x2a_ff;
      x3b_ff <= x3a_ff;
      x4b_ff <= x4r;
      p3_ff  <= mul_start(x3a_ff ^ x1r, keys[4]);
      x1c_ff <= x1b_ff;
      x2c_ff <= x2b_ff;
      x3c_ff <= x3b_ff;
      x4c_ff <= x4b_ff;
      x3m_ff <= x3m_in;
      p5_ff  <= mul_start(16'((x2b_ff ^ x4b_ff) + x3m_in), keys[5]);
      out_ff <= out_in;
   end

   assign out_valid = vd_ff;
   assign out_blk   = out_ff;
endmodule

### sv/idea_out_cell.sv
// IDEA output transform, two pipeline stages; swaps the middle words.
// Depends on idea_pkg.
module idea_out_cell import idea_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  blk_type     in_blk,
   input  logic [3:0][15:0] keys,
   output logic        out_valid,
   output blk_type     out_blk
);
   logic         va_ff, vb_ff;
   mul_part_type p1_ff, p4_ff;
   logic [15:0]  a2_ff, a3_ff;
   blk_type      out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
      p1_ff <= mul_start(in_blk.x1, keys[0]);
      a3_ff <= 16'(in_blk.x3 + keys[1]);
      a2_ff <= 16'(in_blk.x2 + keys[2]);
      p4_ff <= mul_start(in_blk.x4, keys[3]);
      out_ff.x1 <= mul_finish(p1_ff);
      out_ff.x2 <= a3_ff;
      out_ff.x3 <= a2_ff;
      out_ff.x4 <= mul_finish(p4_ff);
   end

   assign out_valid = vb_ff;
   assign out_blk   = out_ff;
endmodule

### sv/idea_inv_unit.sv
// Multiplicative inverse mod 65537 by a^65535, each multiply split into a start and a finish phase.
// Depends on idea_pkg.
module idea_inv_unit import idea_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [15:0] value,
   output logic        done,
   output logic [15:0] result
);
   localparam logic [4:0] LAST_STEP = 5'd29;

   logic         run_ff, phase_ff, done_ff;
   logic [4:0]   cnt_ff;
   logic [15:0]  acc_ff, base_ff;
   mul_part_type part_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         phase_ff <= 1'b0;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff   <= 1'b1;
            phase_ff <= 1'b0;
            cnt_ff   <= '0;
         end else if (run_ff) begin
            phase_ff <= ~phase_ff;
            if (phase_ff) begin
               if (cnt_ff == LAST_STEP) begin
                  run_ff  <= 1'b0;
                  done_ff <= 1'b1;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
         end
      end
      if (go) begin
         acc_ff  <= value;
         base_ff <= value;
      end else if (run_ff) begin
         // square on even steps, times base on odd steps
         if (!phase_ff) part_ff <= mul_start(acc_ff, cnt_ff[0] ? base_ff : acc_ff);
         else           acc_ff  <= mul_finish(part_ff);
      end
   end

   assign done   = done_ff;
   assign result = acc_ff;
endmodule

### sv/idea_block_cipher.sv
// IDEA 64-bit block cipher top level: config registers, key schedule with
// inverse sequencer, and a chain of round cells. Depends on idea_pkg and all cells.
//
//  channel   ports                                   beat taken when
//  request   start, busy, req_block_in               start && !busy
//  response  rsp_valid, rsp_block_out                rsp_valid (no back-pressure)
//  config    csr_valid, csr_ready, csr_index, csr_data  csr_valid && csr_ready
//
// One block enters per cycle while busy is low; each result passes through
// four registered stages per round cell and two in the output cell.
// The receiver cannot stall, so the chain never holds.
// A write to a decoded config register recomputes the 2*(ROUNDS+1) decryption
// inverses through one shared inverse unit; busy stays high meanwhile.
// Reset clears valid bits, config registers and the sequencer.
module idea_block_cipher import idea_pkg::*; #(
   parameter int ROUNDS = ROUNDS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [63:0]          req_block_in,
   output logic                 rsp_valid,
   output logic [63:0]          rsp_block_out,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_data
);
   localparam int KEY_COUNT = 6 * ROUNDS + 4;
   localparam int NINV      = 2 * (ROUNDS + 1);
   localparam int IDXW      = $clog2(NINV);

   localparam logic [1:0] SEQ_IDLE   = 2'd0;
   localparam logic [1:0] SEQ_LAUNCH = 2'd1;
   localparam logic [1:0] SEQ_WAIT   = 2'd2;

   logic [63:0]     key_upper_ff, key_lower_ff;
   logic            mode_ff;
   logic [1:0]      seq_ff;
   logic [IDXW-1:0] idx_ff;
   logic [15:0]     inv_ff [NINV];

   logic [127:0]    key;
   logic [15:0]     ek [KEY_COUNT];
   logic [15:0]     inv_src [NINV];
   logic            csr_hit, csr_take, inv_done;
   logic [15:0]     inv_result;

   assign key       = {key_upper_ff, key_lower_ff};
   assign csr_ready = (seq_ff == SEQ_IDLE);
   assign busy      = (seq_ff != SEQ_IDLE);
   assign csr_take  = csr_valid && csr_ready;
   always_comb csr_hit = csr_index inside {CSR_KEY_UPPER, CSR_KEY_LOWER, CSR_MODE};

   // encryption subkeys are pure wiring of the rotated key
   for (genvar k = 0; k < KEY_COUNT; k++) begin : g_ek
      assign ek[k] = ek_word(key, k);
   end
   for (genvar j = 0; j <= ROUNDS; j++) begin : g_src
      assign inv_src[2*j]   = ek[6*j];
      assign inv_src[2*j+1] = ek[6*j+3];
   end

   // config registers; hold outside a write beat
   always_ff @(posedge clock) begin
      if (reset) begin
         key_upper_ff <= '0;
         key_lower_ff <= '0;
         mode_ff      <= 1'b0;
      end else if (csr_take) begin
         case (csr_index)
            CSR_KEY_UPPER: key_upper_ff <= csr_data;
            CSR_KEY_LOWER: key_lower_ff <= csr_data;
            CSR_MODE:      mode_ff      <= csr_data[0];
            default:       ;
         endcase
      end
   end

   // inverse sequencer: walk every inverse the decryption schedule needs
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= SEQ_IDLE;
         idx_ff <= '0;
      end else begin
         case (seq_ff)
            SEQ_IDLE: begin
               if (csr_take && csr_hit) begin
                  seq_ff <= SEQ_LAUNCH;
                  idx_ff <= '0;
               end
            end
            SEQ_LAUNCH: seq_ff <= SEQ_WAIT;
            SEQ_WAIT: begin
               if (inv_done) begin
                  if (idx_ff == IDXW'(NINV - 1)) begin
                     seq_ff <= SEQ_IDLE;
                  end else begin
                     idx_ff <= idx_ff + IDXW'(1);
                     seq_ff <= SEQ_LAUNCH;
                  end
               end
            end
            default: seq_ff <= SEQ_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (seq_ff == SEQ_WAIT && inv_done) inv_ff[idx_ff] <= inv_result;
   end

   idea_inv_unit u_inv (
      .clock  (clock),
      .reset  (reset),
      .go     (seq_ff == SEQ_LAUNCH),
      .value  (inv_src[idx_ff]),
      .done   (inv_done),
      .result (inv_result)
   );

   // chain of round cells
   logic    chain_v [ROUNDS+1];
   blk_type chain_b [ROUNDS+1];

   assign chain_v[0] = start && !busy;
   assign chain_b[0] = req_block_in;

   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      localparam int SRC = 6 * (ROUNDS - r);
      localparam int A1  = (r != 0) ? 2 : 1;
      localparam int A2  = (r != 0) ? 1 : 2;
      subkeys_type keys;
      always_comb begin
         if (mode_ff) begin
            keys[0] = inv_ff[2*(ROUNDS-r)];
            keys[1] = 16'(16'd0 - ek[SRC+A1]);
            keys[2] = 16'(16'd0 - ek[SRC+A2]);
            keys[3] = inv_ff[2*(ROUNDS-r)+1];
            keys[4] = ek[SRC-2];
            keys[5] = ek[SRC-1];
         end else begin
            for (int i = 0; i < 6; i++) keys[i] = ek[6*r+i];
         end
      end
      idea_round_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_v[r]),
         .in_blk    (chain_b[r]),
         .keys      (keys),
         .out_valid (chain_v[r+1]),
         .out_blk   (chain_b[r+1])
      );
   end

   logic [3:0][15:0] out_keys;
   blk_type          out_blk;

   always_comb begin
      if (mode_ff) begin
         out_keys[0] = inv_ff[0];
         out_keys[1] = 16'(16'd0 - ek[1]);
         out_keys[2] = 16'(16'd0 - ek[2]);
         out_keys[3] = inv_ff[1];
      end else begin
         for (int i = 0; i < 4; i++) out_keys[i] = ek[6*ROUNDS+i];
      end
   end

   idea_out_cell u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_v[ROUNDS]),
      .in_blk    (chain_b[ROUNDS]),
      .keys      (out_keys),
      .out_valid (rsp_valid),
      .out_blk   (out_blk)
   );

   assign rsp_block_out = out_blk;

   // a register write always starts a key rebuild
   a_write_rebuilds: assert property (@(posedge clock) disable iff (reset)
      (csr_take && csr_hit) |=> busy)
      else $error("config write did not start key rebuild");

   a_no_csr_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !csr_ready)
      else $error("config port open during key rebuild");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy |-> (idx_ff <= IDXW'(NINV - 1)))
      else $error("inverse index out of range");
endmodule

### tb/tb_top.sv
// Self-checking testbench for idea_block_cipher: drives blocks and key/mode
// writes, predicts each output block and compares. Depends on idea_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top import idea_pkg::*; ();

   localparam int NUM_ROUNDS  = 8;
   localparam int KEY_WORDS   = 52;
   localparam int LATENCY     = 4 * NUM_ROUNDS + 2;
   localparam int DRAIN_WAIT  = LATENCY + 8;
   localparam int STALL_LIMIT = 40000;
   // Index 3 decodes to no register; writes to it must be dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [63:0]          req_block_in = '0;
   logic                 rsp_valid;
   logic [63:0]          rsp_block_out;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0]          csr_data = '0;

   idea_block_cipher dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: shadow registers and the active subkey table.
   logic [63:0] key_hi_q, key_lo_q;
   logic        decrypt_q;
   logic [15:0] subkey_tab [KEY_WORDS];

   logic [63:0] pending_blocks[$];
   logic [63:0] expected_blocks[$];
   int          error_count   = 0;
   int          blocks_sent   = 0;
   int          blocks_seen   = 0;
   int          decrypt_runs  = 0;
   bit          hold_sender   = 1'b0;
   bit          idle_enable   = 1'b0;

   // Multiply mod 65537 with 0 standing for 65536.
   function automatic logic [15:0] mul_p(input logic [15:0] a, input logic [15:0] b);
      longint unsigned x, y;
      x = (a == 0) ? 65536 : a;
      y = (b == 0) ? 65536 : b;
      return 16'((x * y) % 65537);
   endfunction

   // Inverse by Fermat: a^(p-2) mod p. Zero and one map to themselves.
   function automatic logic [15:0] inv_p(input logic [15:0] a);
      longint unsigned base, acc;
      int unsigned     e;
      base = (a == 0) ? 65536 : a;
      acc  = 1;
      e    = 65535;
      while (e != 0) begin
         if (e[0]) acc = (acc * base) % 65537;
         base = (base * base) % 65537;
         e = e >> 1;
      end
      return 16'(acc);
   endfunction

   // Rebuild the subkey table from the shadow key and mode.
   function automatic void expand_subkeys();
      logic [127:0] k;
      logic [15:0]  enc [KEY_WORDS];
      int           src;
      bit           swap;
      k = {key_hi_q, key_lo_q};
      for (int i = 0; i < KEY_WORDS; i++) begin
         if (i != 0 && i % 8 == 0) k = {k[102:0], k[127:103]};
         enc[i] = k[127 - 16 * (i % 8) -: 16];
      end
      if (!decrypt_q) begin
         for (int i = 0; i < KEY_WORDS; i++) subkey_tab[i] = enc[i];
         return;
      end
      for (int r = 0; r <= NUM_ROUNDS; r++) begin
         src  = 6 * (NUM_ROUNDS - r);
         swap = (r != 0) && (r != NUM_ROUNDS);
         subkey_tab[6*r]   = inv_p(enc[src]);
         subkey_tab[6*r+1] = 16'(0) - enc[src + (swap ? 2 : 1)];
         subkey_tab[6*r+2] = 16'(0) - enc[src + (swap ? 1 : 2)];
         subkey_tab[6*r+3] = inv_p(enc[src+3]);
         if (r < NUM_ROUNDS) begin
            subkey_tab[6*r+4] = enc[src-2];
            subkey_tab[6*r+5] = enc[src-1];
         end
      end
   endfunction

   function automatic logic [63:0] cipher_block(input logic [63:0] blk);
      logic [15:0] x1, x2, x3, x4, s2, s3;
      int          b;
      {x1, x2, x3, x4} = blk;
      for (int r = 0; r < NUM_ROUNDS; r++) begin
         b  = 6 * r;
         x1 = mul_p(x1, subkey_tab[b]);
         x2 = x2 + subkey_tab[b+1];
         x3 = x3 + subkey_tab[b+2];
         x4 = mul_p(x4, subkey_tab[b+3]);
         s3 = x3;
         x3 = mul_p(x3 ^ x1, subkey_tab[b+4]);
         s2 = x2;
         x2 = mul_p((x2 ^ x4) + x3, subkey_tab[b+5]);
         x3 = x3 + x2;
         x1 ^= x2;
         x4 ^= x3;
         x2 ^= s3;
         x3 ^= s2;
      end
      b = 6 * NUM_ROUNDS;
      x1 = mul_p(x1, subkey_tab[b]);
      x3 = x3 + subkey_tab[b+1];
      x2 = x2 + subkey_tab[b+2];
      x4 = mul_p(x4, subkey_tab[b+3]);
      return {x1, x3, x2, x4};
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("[%0t] MISMATCH %s: got %h want %h", $time, what, got, want);
      error_count++;
   endtask

   // Driver: present the head of the pending queue, pop it on each accepted
   // beat and record its prediction. Draw a fresh gap per block.
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         logic took;
         took = start && !busy;
         if (took) begin
            expected_blocks.push_back(cipher_block(req_block_in));
            void'(pending_blocks.pop_front());
            blocks_sent++;
            gap_left = idle_enable ? $urandom_range(0, 17) : 0;
         end else if (!start && gap_left > 0) begin
            gap_left--;
         end
         if (pending_blocks.size() > 0 && !hold_sender &&
             (gap_left == 0 || (start && !took))) begin
            start        <= 1'b1;
            req_block_in <= pending_blocks[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobed result must match the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         blocks_seen++;
         if (expected_blocks.size() == 0)
            report_mismatch("unexpected result", rsp_block_out, 64'h0);
         else if (rsp_block_out !== expected_blocks[0])
            report_mismatch("block_out", rsp_block_out, expected_blocks.pop_front());
         else
            void'(expected_blocks.pop_front());
      end
   end

   // Watchdog: count cycles in which no beat moves on any channel.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[%0t] watchdog: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Write one register; hold valid until ready, then update the shadow copy.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_KEY_UPPER: key_hi_q  = data;
         CSR_KEY_LOWER: key_lo_q  = data;
         CSR_MODE:      decrypt_q = data[0];
         default:       return;
      endcase
      expand_subkeys();
   endtask

   // Wait for everything queued to go through, then let the pipe settle.
   task automatic drain();
      while (pending_blocks.size() > 0 || expected_blocks.size() > 0 || start)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic load_key(input logic [63:0] hi, input logic [63:0] lo,
                           input logic [63:0] mode_word);
      csr_write(CSR_KEY_UPPER, hi);
      csr_write(CSR_KEY_LOWER, lo);
      csr_write(CSR_MODE, mode_word);
      if (mode_word[0]) decrypt_runs++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Random block: mostly uniform, some with zero, one or all-ones words to hit the
   // zero-operand multiply path.
   function automatic logic [63:0] random_block();
      logic [63:0] v;
      v = rand64();
      if ($urandom_range(0, 5) == 0)
         for (int w = 0; w < 4; w++)
            case ($urandom_range(0, 3))
               0: v[16*w +: 16] = 16'h0000;
               1: v[16*w +: 16] = 16'h0001;
               2: v[16*w +: 16] = 16'hFFFF;
               default: ;
            endcase
      return v;
   endfunction

   function automatic logic [63:0] random_key_half();
      case ($urandom_range(0, 7))
         0: return 64'h0;
         1: return '1;
         default: return rand64();
      endcase
   endfunction

   localparam logic [63:0] DIRECTED [12] = '{
      64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
      64'h0001_0001_0001_0001, 64'h0000_FFFF_0000_FFFF,
      64'hFFFF_0000_FFFF_0000, 64'h8000_0000_0000_0001,
      64'h0000_0001_0002_0003, 64'h0102_0304_0506_0708,
      64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
      64'h0001_0000_0000_0000, 64'h0000_0000_0000_8000
   };

   initial begin
      int phases;
      key_hi_q  = '0;
      key_lo_q  = '0;
      decrypt_q = 1'b0;
      expand_subkeys();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset key first, then all-ones key in decrypt mode.
      foreach (DIRECTED[i]) pending_blocks.push_back(DIRECTED[i]);
      drain();
      load_key('1, '1, 64'h1);
      foreach (DIRECTED[i]) pending_blocks.push_back(DIRECTED[i]);
      drain();
      // Drop a write to the unused index; subkeys must stay put.
      csr_write(CSR_UNUSED, rand64());
      pending_blocks.push_back(64'h0123_4567_89AB_CDEF);
      drain();

      // Random phases: fresh key and mode each time, with garbage in the
      // upper mode bits. Every third phase runs back-to-back, the rest with idle gaps.
      phases = 0;
      while (blocks_sent < 1550) begin
         load_key(random_key_half(), random_key_half(),
                  (rand64() & ~64'h1) | 64'($urandom_range(0, 1)));
         idle_enable = (phases % 3) != 1;
         for (int n = 0; n < 120; n++) begin
            pending_blocks.push_back(random_block());
            // Occasionally stop feeding until all results are back.
            if (n == 60 && phases % 4 == 2) begin
               while (pending_blocks.size() > 0) @(posedge clock);
               hold_sender = 1'b1;
               while (start || expected_blocks.size() > 0) @(posedge clock);
               hold_sender = 1'b0;
            end
         end
         drain();
         phases++;
      end

      drain();
      if (expected_blocks.size() > 0)
         report_mismatch("results never arrived", 64'(expected_blocks.size()), 64'h0);
      $display("covered %0d blocks sent, %0d results, %0d key phases (%0d decrypt)",
               blocks_sent, blocks_seen, phases + 2, decrypt_runs);
      $display("mismatch count: %0d", error_count);
      if (error_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

### filelist.f
sv/idea_pkg.sv
sv/idea_round_cell.sv
sv/idea_out_cell.sv
sv/idea_inv_unit.sv
sv/idea_block_cipher.sv
tb/tb_top.sv
